/* rtl/dpke_pkg.sv */
// Shared types and constants of the degenerate pattern k-mer expander.
package dpke_pkg;

  localparam int MaxPositions = 15;
  localparam int PosW         = 4;
  localparam int WordW        = 30;

  typedef enum logic [1:0] {
    OP_CHAR  = 2'd0,
    OP_CHECK = 2'd1,
    OP_FETCH = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BADCHAR   = 3'd1,
    ST_TOOLONG   = 3'd2,
    ST_MISMATCH  = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_EXHAUSTED = 3'd5,
    ST_NOTPARSED = 3'd6
  } status_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] iupac;
    logic [3:0] single;
    logic       is_open;
    logic       is_close;
    logic       is_star;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

endpackage

/* rtl/dpke_front.sv */
// Front end: decodes pattern characters and holds decoded items in a two-entry queue.
module dpke_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [1:0]      in_operation,
  input  logic [7:0]      in_character,
  input  logic            pop,
  output logic            busy,
  output dpke_pkg::queue_t head
);
  import dpke_pkg::*;

  function automatic logic [3:0] iupac_mask(input logic [7:0] c);
    logic [3:0] m;
    case (c)
      ".":     m = 4'hF;
      "A":     m = 4'd1;
      "C":     m = 4'd2;
      "G":     m = 4'd4;
      "T":     m = 4'd8;
      "U":     m = 4'd8;
      "W":     m = 4'd9;
      "S":     m = 4'd6;
      "K":     m = 4'd12;
      "M":     m = 4'd3;
      "R":     m = 4'd5;
      "Y":     m = 4'd10;
      "B":     m = 4'd14;
      "V":     m = 4'd7;
      "H":     m = 4'd11;
      "D":     m = 4'd13;
      default: m = 4'd0;
    endcase
    return m;
  endfunction

  function automatic logic [3:0] single_base(input logic [7:0] c);
    logic [3:0] m;
    case (c)
      "A":     m = 4'd1;
      "C":     m = 4'd2;
      "G":     m = 4'd4;
      "T":     m = 4'd8;
      default: m = 4'd0;
    endcase
    return m;
  endfunction

  item_t      entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  item_t      decoded;
  logic       push;
  logic       do_pop;

  always_comb begin
    decoded.op       = op_t'(in_operation);
    decoded.iupac    = iupac_mask(in_character);
    decoded.single   = single_base(in_character);
    decoded.is_open  = (in_character == "[");
    decoded.is_close = (in_character == "]");
    decoded.is_star  = (in_character == "*");
  end

  assign busy   = (fill_r == 2'd2);
  assign push   = start && !busy;
  assign do_pop = pop && (fill_r != 2'd0);

  assign head.valid = (fill_r != 2'd0);
  assign head.item  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        entry_r[wr_ptr_r] <= decoded;
        wr_ptr_r          <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      fill_r <= fill_r + 2'(push) - 2'(do_pop);
    end
  end

endmodule

/* rtl/dpke_back.sv */
// Back end: pattern store, length check and odometer that produces the expanded words.
module dpke_back (
  input  logic             clk,
  input  logic             rst_n,
  input  dpke_pkg::queue_t head,
  input  logic [3:0]       required_length,
  output logic             pop,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [29:0]      out_word,
  output logic [3:0]       out_word_length,
  output logic             out_last_word
);
  import dpke_pkg::*;

  typedef enum logic [1:0] {
    PH_LOADING   = 2'd0,
    PH_READY     = 2'd1,
    PH_EXHAUSTED = 2'd2,
    PH_FAILED    = 2'd3
  } phase_t;

  typedef struct packed {
    logic       found;
    logic [1:0] base;
  } base_sel_t;

  function automatic base_sel_t next_base(input logic [3:0] mask, input logic [1:0] cur,
                                          input logic from_start);
    base_sel_t r;
    r = '0;
    for (int b = 3; b >= 0; b--) begin
      if (mask[b] && (from_start || b > int'(cur))) begin
        r.found = 1'b1;
        r.base  = 2'(b);
      end
    end
    return r;
  endfunction

  logic [3:0]       masks_r  [MaxPositions];
  logic [3:0]       masks_nxt[MaxPositions];
  logic [1:0]       chosen_r  [MaxPositions];
  logic [1:0]       chosen_nxt[MaxPositions];
  logic [PosW-1:0]  count_r,    count_nxt;
  logic             brackets_r, brackets_nxt;
  status_t          err_r,      err_nxt;
  phase_t           phase_r,    phase_nxt;
  status_t          status_r,   status_nxt;
  logic [WordW-1:0] word_r,     word_nxt;
  logic             last_r,     last_nxt;
  logic             valid_r;
  base_sel_t        first_sel[MaxPositions];
  base_sel_t        succ_sel [MaxPositions];
  item_t            it;

  assign it  = head.item;
  assign pop = head.valid;

  always_comb begin
    for (int i = 0; i < MaxPositions; i++) begin
      first_sel[i] = next_base(masks_r[i], 2'd0, 1'b1);
      succ_sel[i]  = next_base(masks_r[i], chosen_r[i], 1'b0);
    end
  end

  always_comb begin
    logic [PosW-1:0] count_c;
    logic            br_c;
    status_t         err_c;
    logic            any_zero;
    logic            carry_found;
    logic [PosW-1:0] carry_idx;

    masks_nxt    = masks_r;
    chosen_nxt   = chosen_r;
    count_nxt    = count_r;
    brackets_nxt = brackets_r;
    err_nxt      = err_r;
    phase_nxt    = phase_r;
    status_nxt   = err_r;
    word_nxt     = '0;
    last_nxt     = 1'b0;
    count_c      = count_r;
    br_c         = brackets_r;
    err_c        = err_r;
    any_zero     = 1'b0;
    carry_found  = 1'b0;
    carry_idx    = '0;

    case (it.op)
      OP_CHAR: begin
        if (phase_r != PH_LOADING) begin
          count_c   = '0;
          br_c      = 1'b0;
          err_c     = ST_OK;
          phase_nxt = PH_LOADING;
        end
        if (err_c != ST_OK) begin
          err_c = err_c;
        end else if (int'(count_c) >= MaxPositions) begin
          err_c = ST_TOOLONG;
        end else if (br_c) begin
          if (it.is_close) begin
            br_c    = 1'b0;
            count_c = count_c + 1'b1;
          end else if (it.single == 4'd0) begin
            err_c = ST_BADCHAR;
          end else begin
            masks_nxt[count_c] = masks_r[count_c] | it.single;
          end
        end else if (it.is_open) begin
          br_c               = 1'b1;
          masks_nxt[count_c] = 4'd0;
        end else if (it.is_star) begin
          if (count_c != '0) begin
            for (int j = 0; j < MaxPositions; j++) begin
              if (j >= int'(count_c) && j < int'(required_length)) begin
                masks_nxt[j] = masks_r[PosW'(count_c - 1'b1)];
              end
            end
            if (required_length > count_c) begin
              count_c = required_length;
            end
          end
        end else if (it.iupac == 4'd0) begin
          err_c = ST_BADCHAR;
        end else begin
          masks_nxt[count_c] = it.iupac;
          count_c            = count_c + 1'b1;
        end
        count_nxt    = count_c;
        brackets_nxt = br_c;
        err_nxt      = err_c;
        status_nxt   = err_c;
      end
      OP_CHECK: begin
        if (err_r != ST_BADCHAR && err_r != ST_TOOLONG) begin
          if (count_r == '0) begin
            err_c = ST_EMPTY;
          end else if (required_length != 4'd0 && count_r != required_length) begin
            err_c = ST_MISMATCH;
          end else begin
            err_c = ST_OK;
          end
        end
        if (err_c != ST_OK) begin
          phase_nxt = PH_FAILED;
        end else begin
          for (int i = 0; i < MaxPositions; i++) begin
            if (i < int'(count_r)) begin
              chosen_nxt[i] = first_sel[i].base;
              if (!first_sel[i].found) begin
                any_zero = 1'b1;
              end
            end
          end
          phase_nxt = any_zero ? PH_EXHAUSTED : PH_READY;
        end
        err_nxt    = err_c;
        status_nxt = err_c;
      end
      OP_FETCH: begin
        case (phase_r)
          PH_LOADING:   status_nxt = ST_NOTPARSED;
          PH_FAILED:    status_nxt = err_r;
          PH_EXHAUSTED: status_nxt = ST_EXHAUSTED;
          PH_READY: begin
            status_nxt = ST_OK;
            for (int i = 0; i < MaxPositions; i++) begin
              if (i < int'(count_r)) begin
                word_nxt = {word_nxt[WordW-3:0], chosen_r[i]};
                if (succ_sel[i].found) begin
                  carry_found = 1'b1;
                  carry_idx   = PosW'(i);
                end
              end
            end
            last_nxt = !carry_found;
            if (!carry_found) begin
              phase_nxt = PH_EXHAUSTED;
            end else begin
              for (int i = 0; i < MaxPositions; i++) begin
                if (i < int'(count_r)) begin
                  if (i == int'(carry_idx)) begin
                    chosen_nxt[i] = succ_sel[i].base;
                  end else if (i > int'(carry_idx)) begin
                    chosen_nxt[i] = first_sel[i].base;
                  end
                end
              end
            end
          end
          default: status_nxt = err_r;
        endcase
      end
      default: status_nxt = err_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      brackets_r <= 1'b0;
      err_r      <= ST_OK;
      phase_r    <= PH_LOADING;
      valid_r    <= 1'b0;
    end else begin
      valid_r <= pop;
      if (pop) begin
        masks_r    <= masks_nxt;
        chosen_r   <= chosen_nxt;
        count_r    <= count_nxt;
        brackets_r <= brackets_nxt;
        err_r      <= err_nxt;
        phase_r    <= phase_nxt;
        status_r   <= status_nxt;
        word_r     <= word_nxt;
        last_r     <= last_nxt;
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_word        = word_r;
  assign out_word_length = count_r;
  assign out_last_word   = last_r;

endmodule

/* rtl/degenerate_pattern_kmer_expander.sv */
// Top level of the degenerate pattern k-mer expander.
// Accepted items pass through the queue, then the back end registers their results.
// One item per cycle while busy is low; the back end finishes each item as it pops.
// busy rises only when the two-entry queue between front and back end is full.
// Synchronous active-low reset clears the pattern, phase, queue and required length.
// Results are strobed for one cycle each; the receiver cannot stall.
module degenerate_pattern_kmer_expander (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_character,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [29:0] out_word,
  output logic [3:0]  out_word_length,
  output logic        out_last_word,
  input  logic        cfg_write_enable,
  input  logic [3:0]  cfg_required_length
);
  import dpke_pkg::*;

  logic [3:0] required_length_r;
  queue_t     head;
  logic       pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      required_length_r <= 4'd0;
    end else if (cfg_write_enable) begin
      required_length_r <= cfg_required_length;
    end
  end

  dpke_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .in_character (in_character),
    .pop          (pop),
    .busy         (busy),
    .head         (head)
  );

  dpke_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .required_length (required_length_r),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_word        (out_word),
    .out_word_length (out_word_length),
    .out_last_word   (out_last_word)
  );

  a_result_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(head.valid))
    else $error("Result strobe without a queued item.");

  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> head.valid)
    else $error("Accepted item did not reach the queue.");

  a_last_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_word) |-> (out_status == ST_OK))
    else $error("Final word flagged with a failing status.");

endmodule

/* tb/tb_degenerate_pattern_kmer_expander.sv */
// Self-checking testbench of the degenerate pattern k-mer expander: pattern, check, fetch and no-operation items.
`timescale 1ns / 1ps

module tb_degenerate_pattern_kmer_expander;
  import dpke_pkg::*;

  localparam int CycleLimit = 300000;

  typedef enum logic [1:0] {
    PH_LOAD,
    PH_READY,
    PH_DONE,
    PH_FAIL
  } phase_t;

  typedef struct {
    op_t        op;
    logic [7:0] ch;
  } pattern_item_t;

  typedef struct {
    status_t     status;
    logic [29:0] word;
    logic [3:0]  len;
    logic        last;
  } kmer_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_operation = 2'd0;
  logic [7:0]  in_character = 8'd0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [29:0] out_word;
  logic [3:0]  out_word_length;
  logic        out_last_word;
  logic        cfg_write_enable = 1'b0;
  logic [3:0]  cfg_required_length = 4'd0;

  logic [3:0]  pos_mask [MaxPositions] = '{default: 4'd0};
  logic [1:0]  base_sel [MaxPositions] = '{default: 2'd0};
  int unsigned pos_count = 0;
  logic        open_set = 1'b0;
  status_t     parse_status = ST_OK;
  phase_t      phase = PH_LOAD;
  int unsigned need_len = 0;

  pattern_item_t pending_items[$];
  kmer_result_t  awaited_results[$];
  pattern_item_t cur_item;
  kmer_result_t  seen_want;
  int unsigned   queued_count = 0;
  int unsigned   accepted_count = 0;
  int            idle_left = 0;
  logic          quiet_tail = 1'b0;
  int            errors = 0;
  int            cycles = 0;

  degenerate_pattern_kmer_expander dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_character        (in_character),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_word            (out_word),
    .out_word_length     (out_word_length),
    .out_last_word       (out_last_word),
    .cfg_write_enable    (cfg_write_enable),
    .cfg_required_length (cfg_required_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int first_base_from(logic [3:0] mask, int from);
    for (int b = from; b < 4; b++) begin
      if (mask[b]) return b;
    end
    return 4;
  endfunction

  function automatic kmer_result_t predict_expander(pattern_item_t it);
    kmer_result_t r;
    logic [3:0]   m;
    int           nb;
    logic         any_empty;
    r.status = ST_OK;
    r.word = '0;
    r.last = 1'b0;
    case (it.op)
      OP_CHAR: begin
        if (phase != PH_LOAD) begin
          for (int i = 0; i < MaxPositions; i++) begin
            pos_mask[i] = 4'd0;
            base_sel[i] = 2'd0;
          end
          pos_count = 0;
          open_set = 1'b0;
          parse_status = ST_OK;
          phase = PH_LOAD;
        end
        if (parse_status == ST_OK) begin
          if (pos_count >= MaxPositions) begin
            parse_status = ST_TOOLONG;
          end else if (open_set) begin
            if (it.ch == "]") begin
              open_set = 1'b0;
              pos_count++;
            end else begin
              case (it.ch)
                "A": m = 4'd1;
                "C": m = 4'd2;
                "G": m = 4'd4;
                "T": m = 4'd8;
                default: m = 4'd0;
              endcase
              if (m == 4'd0) parse_status = ST_BADCHAR;
              else pos_mask[pos_count] = pos_mask[pos_count] | m;
            end
          end else if (it.ch == "[") begin
            open_set = 1'b1;
            pos_mask[pos_count] = 4'd0;
          end else if (it.ch == "*") begin
            while (pos_count > 0 && pos_count < need_len && pos_count < MaxPositions) begin
              pos_mask[pos_count] = pos_mask[pos_count - 1];
              pos_count++;
            end
          end else begin
            case (it.ch)
              ".": m = 4'hF;
              "A": m = 4'd1;
              "C": m = 4'd2;
              "G": m = 4'd4;
              "T", "U": m = 4'd8;
              "W": m = 4'd9;
              "S": m = 4'd6;
              "K": m = 4'd12;
              "M": m = 4'd3;
              "R": m = 4'd5;
              "Y": m = 4'd10;
              "B": m = 4'd14;
              "V": m = 4'd7;
              "H": m = 4'd11;
              "D": m = 4'd13;
              default: m = 4'd0;
            endcase
            if (m == 4'd0) begin
              parse_status = ST_BADCHAR;
            end else begin
              pos_mask[pos_count] = m;
              pos_count++;
            end
          end
        end
        r.status = parse_status;
      end
      OP_CHECK: begin
        if (parse_status != ST_BADCHAR && parse_status != ST_TOOLONG) begin
          if (pos_count == 0) parse_status = ST_EMPTY;
          else if (need_len != 0 && pos_count != need_len) parse_status = ST_MISMATCH;
          else parse_status = ST_OK;
        end
        if (parse_status != ST_OK) begin
          phase = PH_FAIL;
        end else begin
          any_empty = 1'b0;
          for (int i = 0; i < int'(pos_count); i++) begin
            nb = first_base_from(pos_mask[i], 0);
            if (nb > 3) begin
              any_empty = 1'b1;
              nb = 0;
            end
            base_sel[i] = 2'(nb);
          end
          phase = any_empty ? PH_DONE : PH_READY;
        end
        r.status = parse_status;
      end
      OP_FETCH: begin
        if (phase == PH_LOAD) begin
          r.status = ST_NOTPARSED;
        end else if (phase == PH_FAIL) begin
          r.status = parse_status;
        end else if (phase == PH_DONE) begin
          r.status = ST_EXHAUSTED;
        end else begin
          r.last = 1'b1;
          for (int i = 0; i < int'(pos_count); i++) begin
            r.word = (r.word << 2) | 30'(base_sel[i]);
            if (first_base_from(pos_mask[i], int'(base_sel[i]) + 1) < 4) r.last = 1'b0;
          end
          if (r.last) begin
            phase = PH_DONE;
          end else begin
            for (int i = int'(pos_count) - 1; i >= 0; i--) begin
              nb = first_base_from(pos_mask[i], int'(base_sel[i]) + 1);
              if (nb < 4) begin
                base_sel[i] = 2'(nb);
                break;
              end
              base_sel[i] = 2'(first_base_from(pos_mask[i], 0));
            end
          end
        end
      end
      default: r.status = parse_status;
    endcase
    r.len = 4'(pos_count);
    return r;
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        awaited_results.push_back(predict_expander(cur_item));
        accepted_count++;
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (pending_items.size() == 0) begin
          start <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
          idle_left = $urandom_range(1, 9) - 1;
          start <= 1'b0;
        end else begin
          cur_item = pending_items.pop_front();
          start <= 1'b1;
          in_operation <= cur_item.op;
          in_character <= cur_item.ch;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d word %h", $time, out_status, out_word);
        errors++;
      end else begin
        seen_want = awaited_results.pop_front();
        if (out_status !== seen_want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, seen_want.status, out_status);
          errors++;
        end
        if (out_word !== seen_want.word) begin
          $display("%0t: word expected %h, got %h", $time, seen_want.word, out_word);
          errors++;
        end
        if (out_word_length !== seen_want.len) begin
          $display("%0t: word_length expected %0d, got %0d", $time, seen_want.len,
                   out_word_length);
          errors++;
        end
        if (out_last_word !== seen_want.last) begin
          $display("%0t: last_word expected %0d, got %0d", $time, seen_want.last,
                   out_last_word);
          errors++;
        end
      end
    end
  end

  task automatic push_item(op_t op, logic [7:0] ch);
    pending_items.push_back('{op, ch});
    queued_count++;
  endtask

  task automatic wait_drained();
    while (accepted_count != queued_count || awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_required_length(int unsigned value);
    cfg_required_length <= 4'(value);
    cfg_write_enable <= 1'b1;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    need_len = value;
  endtask

  task automatic queue_pattern_jobs(int unsigned budget);
    string       letters = "ACGTUWSKMRYBVHD.";
    string       bases = "ACGT";
    string       junk = "acgtnN-x";
    int unsigned width_of [16] = '{1, 1, 1, 1, 1, 2, 2, 2, 2, 2, 2, 3, 3, 3, 3, 4};
    int unsigned widths [$];
    int unsigned stop_at, target, kind, pick, idx, words, fetches, breakage, n;
    logic [3:0]  set_mask;
    stop_at = queued_count + budget;
    while (queued_count < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind >= 88) begin
        repeat ($urandom_range(1, 4))
          push_item(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        continue;
      end
      widths.delete();
      if (need_len != 0 && $urandom_range(0, 4) != 0) target = need_len;
      else if ($urandom_range(0, 3) == 0) target = $urandom_range(1, 15);
      else target = $urandom_range(1, 6);
      while (widths.size() < target) begin
        pick = $urandom_range(0, 19);
        if (pick < 11) begin
          idx = $urandom_range(0, 4);
          push_item(OP_CHAR, letters[idx]);
          widths.push_back(width_of[idx]);
        end else if (pick < 15) begin
          idx = $urandom_range(5, 15);
          push_item(OP_CHAR, letters[idx]);
          widths.push_back(width_of[idx]);
        end else if (pick < 18) begin
          set_mask = 4'd0;
          push_item(OP_CHAR, "[");
          n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
          repeat (n) begin
            idx = $urandom_range(0, 3);
            set_mask[idx] = 1'b1;
            push_item(OP_CHAR, bases[idx]);
          end
          push_item(OP_CHAR, "]");
          widths.push_back($countones(set_mask));
        end else if (widths.size() > 0) begin
          push_item(OP_CHAR, "*");
          while (widths.size() < need_len && widths.size() < MaxPositions)
            widths.push_back(widths[$]);
        end
      end
      breakage = 4;
      if (kind >= 75) begin
        breakage = $urandom_range(0, 3);
        case (breakage)
          0: begin
            if ($urandom_range(0, 1) == 0) push_item(OP_CHAR, junk[$urandom_range(0, 7)]);
            else push_item(OP_CHAR, 8'($urandom_range(128, 255)));
          end
          1: begin
            push_item(OP_CHAR, "[");
            repeat ($urandom_range(0, 2)) push_item(OP_CHAR, bases[$urandom_range(0, 3)]);
          end
          2: begin
            repeat (MaxPositions + 1 - widths.size() + $urandom_range(0, 2))
              push_item(OP_CHAR, letters[$urandom_range(0, 15)]);
          end
          default: begin
            push_item(OP_CHAR, "[");
            push_item(OP_CHAR, junk[$urandom_range(0, 7)]);
            push_item(OP_CHAR, "]");
          end
        endcase
      end
      push_item(OP_CHECK, 8'($urandom_range(0, 255)));
      words = 1;
      foreach (widths[i]) begin
        words = words * widths[i];
        if (words > 1000) words = 1000;
      end
      if (breakage != 4 && breakage != 1) fetches = $urandom_range(1, 3);
      else if (words == 0) fetches = $urandom_range(1, 2);
      else if (words <= 40) fetches = words + $urandom_range(0, 2);
      else fetches = $urandom_range(1, 12);
      repeat (fetches) push_item(OP_FETCH, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) begin
        push_item(OP_CHECK, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 3)) push_item(OP_FETCH, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int unsigned len_plan [8] = '{0, 1, 4, 7, 12, 15, 9, 2};
    len_plan[6] = $urandom_range(0, 15);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    push_item(OP_FETCH, 8'h00);
    push_item(OP_CHECK, 8'hFF);
    push_item(OP_NONE, 8'h41);
    push_item(OP_CHAR, 8'h00);
    push_item(OP_CHAR, "C");
    push_item(OP_CHECK, 8'h00);
    push_item(OP_CHAR, "R");
    push_item(OP_CHAR, "[");
    push_item(OP_CHAR, "A");
    push_item(OP_CHAR, "T");
    push_item(OP_CHAR, "]");
    push_item(OP_CHAR, "[");
    push_item(OP_CHECK, 8'h00);
    repeat (5) push_item(OP_FETCH, 8'h00);
    push_item(OP_CHAR, "[");
    push_item(OP_CHAR, "]");
    push_item(OP_CHECK, 8'h00);
    push_item(OP_FETCH, 8'h00);
    wait_drained();

    write_required_length(15);
    push_item(OP_CHAR, "[");
    push_item(OP_CHAR, "A");
    push_item(OP_CHAR, "C");
    push_item(OP_CHAR, "]");
    push_item(OP_CHAR, "*");
    push_item(OP_CHAR, "G");
    push_item(OP_CHECK, 8'h00);
    push_item(OP_FETCH, 8'h00);
    queue_pattern_jobs(200);
    wait_drained();

    foreach (len_plan[p]) begin
      write_required_length(len_plan[p]);
      if (p == 7) quiet_tail = 1'b1;
      queue_pattern_jobs(200);
      wait_drained();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
